// ===== sv/lco_pkg.sv =====
// shared types, constants and helpers for the line clipper
// coordinate widths, payload words, window registers and outcode logic
// no dependencies
package lco_pkg;

  localparam int COORD_BITS  = 16;
  localparam int COORD_EXT_W = COORD_BITS + 1;          // a difference of two coordinates
  localparam int PROD_W      = 2 * COORD_EXT_W;         // magnitude of a product of differences
  localparam int CNT_W       = $clog2(PROD_W);
  localparam int QUOT_CAP_LG = 40;
  localparam int CAP_W       = (PROD_W > QUOT_CAP_LG + 1) ? PROD_W : QUOT_CAP_LG + 1;
  localparam int SUM_W       = CAP_W + 2;
  localparam int CFG_IDX_W   = 8;
  localparam int ROUND_W     = 3;
  localparam logic [ROUND_W-1:0] MAX_ROUNDS = ROUND_W'(4);

  typedef logic signed [COORD_BITS-1:0]  coord_t;
  typedef logic signed [COORD_EXT_W-1:0] diff_t;

  localparam coord_t COORD_MAX = coord_t'((64'd1 << (COORD_BITS - 1)) - 64'd1);
  localparam coord_t COORD_MIN = ~COORD_MAX;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_X_MIN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_Y_MIN = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_X_MAX = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_Y_MAX = CFG_IDX_W'(3);

  // outcode bits
  localparam logic [3:0] CODE_LEFT   = 4'b0001;
  localparam logic [3:0] CODE_RIGHT  = 4'b0010;
  localparam logic [3:0] CODE_BOTTOM = 4'b0100;
  localparam logic [3:0] CODE_TOP    = 4'b1000;

  typedef enum logic [1:0] {
    VERDICT_INSIDE  = 2'd0,
    VERDICT_CLIPPED = 2'd1,
    VERDICT_REJECT  = 2'd2
  } verdict_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_t;

  typedef struct packed {
    verdict_t verdict;
    coord_t   clip_start_x;
    coord_t   clip_start_y;
    coord_t   clip_end_x;
    coord_t   clip_end_y;
  } out_t;

  typedef struct packed {
    coord_t x_min;
    coord_t y_min;
    coord_t x_max;
    coord_t y_max;
  } win_t;

  // request to the shared mul/div unit: base + a*b/d
  typedef struct packed {
    logic   go;
    diff_t  a;
    diff_t  b;
    diff_t  d;
    coord_t base;
  } md_req_t;

  typedef struct packed {
    logic   done;
    coord_t result;
  } md_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_WAIT,
    S_DONE
  } clip_state_t;

  typedef enum logic [1:0] {
    U_IDLE,
    U_MUL,
    U_DIV,
    U_FIN
  } md_state_t;

  function automatic logic [3:0] outcode(coord_t x, coord_t y, win_t w);
    logic [3:0] c;
    c = '0;
    if (y > w.y_max) c = c | CODE_TOP;
    if (y < w.y_min) c = c | CODE_BOTTOM;
    if (x > w.x_max) c = c | CODE_RIGHT;
    if (x < w.x_min) c = c | CODE_LEFT;
    return c;
  endfunction

  function automatic diff_t diff(coord_t p, coord_t q);
    return diff_t'(p) - diff_t'(q);
  endfunction

endpackage

// ===== sv/lco_muldiv.sv =====
// shared arithmetic unit: base + a*b/d, truncated toward zero, saturated
// a multiply step, then a restoring divide one quotient bit per cycle
// depends on lco_pkg
module lco_muldiv (
  input  logic             clk,
  input  logic             rst_n,
  input  lco_pkg::md_req_t req,
  output lco_pkg::md_rsp_t rsp
);

  localparam int EW = lco_pkg::COORD_EXT_W;
  localparam int PW = lco_pkg::PROD_W;

  lco_pkg::md_state_t state_r, state_nxt;

  lco_pkg::diff_t            a_r, b_r, d_r;
  lco_pkg::coord_t           base_r;
  logic                      neg_r;
  logic [EW-1:0]             dmag_r;
  logic [PW-1:0]             prod_r;
  logic [PW-1:0]             quot_r;
  logic [EW-1:0]             rem_r;
  logic [lco_pkg::CNT_W-1:0] cnt_r;

  logic [EW-1:0] amag, bmag;
  logic [EW:0]   rem_sh;
  logic          q_bit;

  logic        [lco_pkg::CAP_W-1:0] q_ext, q_cap;
  logic signed [lco_pkg::SUM_W-1:0] q_signed, sum;

  assign amag   = a_r[EW-1] ? (~a_r + 1'b1) : a_r;
  assign bmag   = b_r[EW-1] ? (~b_r + 1'b1) : b_r;
  assign rem_sh = {rem_r, prod_r[PW-1]};
  assign q_bit  = (rem_sh >= {1'b0, dmag_r});

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lco_pkg::U_IDLE: if (req.go) state_nxt = lco_pkg::U_MUL;
      lco_pkg::U_MUL:  state_nxt = lco_pkg::U_DIV;
      lco_pkg::U_DIV:  if (cnt_r == '0) state_nxt = lco_pkg::U_FIN;
      lco_pkg::U_FIN:  state_nxt = lco_pkg::U_IDLE;
      default:         state_nxt = lco_pkg::U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lco_pkg::U_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      lco_pkg::U_IDLE: begin
        if (req.go) begin
          a_r    <= req.a;
          b_r    <= req.b;
          d_r    <= req.d;
          base_r <= req.base;
        end
      end
      lco_pkg::U_MUL: begin
        prod_r <= PW'(amag) * PW'(bmag);
        dmag_r <= d_r[EW-1] ? (~d_r + 1'b1) : d_r;
        neg_r  <= (a_r[EW-1] ^ b_r[EW-1]) ^ d_r[EW-1];
        rem_r  <= '0;
        quot_r <= '0;
        cnt_r  <= lco_pkg::CNT_W'(PW - 1);
      end
      lco_pkg::U_DIV: begin
        prod_r <= {prod_r[PW-2:0], 1'b0};
        quot_r <= {quot_r[PW-2:0], q_bit};
        rem_r  <= q_bit ? EW'(rem_sh - {1'b0, dmag_r}) : rem_sh[EW-1:0];
        cnt_r  <= cnt_r - 1'b1;
      end
      lco_pkg::U_FIN: ;
      default: ;
    endcase
  end

  // clamp, sign, add to base, saturate
  always_comb begin
    q_ext = lco_pkg::CAP_W'(quot_r);
    if (dmag_r == '0) begin
      q_cap = '0;
    end else if (q_ext > (lco_pkg::CAP_W'(1) << lco_pkg::QUOT_CAP_LG)) begin
      q_cap = lco_pkg::CAP_W'(1) << lco_pkg::QUOT_CAP_LG;
    end else begin
      q_cap = q_ext;
    end
    q_signed = neg_r ? -$signed({2'b00, q_cap}) : $signed({2'b00, q_cap});
    sum      = lco_pkg::SUM_W'(base_r) + q_signed;
    if (sum > lco_pkg::SUM_W'(lco_pkg::COORD_MAX)) begin
      rsp.result = lco_pkg::COORD_MAX;
    end else if (sum < lco_pkg::SUM_W'(lco_pkg::COORD_MIN)) begin
      rsp.result = lco_pkg::COORD_MIN;
    end else begin
      rsp.result = sum[lco_pkg::COORD_BITS-1:0];
    end
    rsp.done = (state_r == lco_pkg::U_FIN);
  end

endmodule

// ===== sv/line_clipper_outcode.sv =====
// top level of the outcode line clipper: window registers, round sequencer
// and the shared mul/div unit that computes each edge crossing
// depends on lco_pkg and lco_muldiv
//
// usage
//   input: drive in_data with a segment and raise start; the word is taken
//   at a rising edge where start is high and busy is low. busy stays high
//   until the result has been shown.
//   output: out_valid is high for exactly one cycle with the result word on
//   out_data; the receiver must take it then, there is no stall.
//   config: cfg_valid/cfg_ready write one window register per word, index
//   0 x_min, 1 y_min, 2 x_max, 3 y_max; other indexes are dropped. cfg_ready
//   is always high; write only while busy is low.
// operation
//   one segment at a time. a segment that needs no move goes from check
//   straight to done, where out_valid is shown. each move is one pass
//   through the shared mul/div unit: issue, multiply, one divide step per
//   product bit, finish with write back. at most four moves; the bit-serial
//   divider sets how long a segment takes.
// reset
//   synchronous active-low reset returns to idle and loads the window
//   x_min = y_min = 0, x_max = y_max = max coordinate.
module line_clipper_outcode (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  lco_pkg::in_t                      in_data,
  output logic                              out_valid,
  output lco_pkg::out_t                     out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lco_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  lco_pkg::coord_t                   cfg_data
);

  lco_pkg::clip_state_t state_r, state_nxt;

  // current endpoints and per-item bookkeeping
  lco_pkg::coord_t              x0_r, y0_r, x1_r, y1_r;
  logic [lco_pkg::ROUND_W-1:0]  round_r;
  lco_pkg::verdict_t            verdict_r, verdict_nxt;
  lco_pkg::win_t                win_r;

  // what the pending move writes back
  logic            mv_first_r, mv_first_nxt;   // move the first endpoint
  logic            horiz_r, horiz_nxt;         // top/bottom edge: new y is the edge
  lco_pkg::coord_t edge_r, edge_nxt;

  logic [3:0]       c0, c1, csel;
  logic             all_in, reject;
  lco_pkg::md_req_t req;
  lco_pkg::md_rsp_t rsp;
  lco_pkg::coord_t  nx, ny;

  assign cfg_ready = 1'b1;

  // window registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r.x_min <= '0;
      win_r.y_min <= '0;
      win_r.x_max <= lco_pkg::COORD_MAX;
      win_r.y_max <= lco_pkg::COORD_MAX;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == lco_pkg::REG_X_MIN) win_r.x_min <= cfg_data;
      if (cfg_index == lco_pkg::REG_Y_MIN) win_r.y_min <= cfg_data;
      if (cfg_index == lco_pkg::REG_X_MAX) win_r.x_max <= cfg_data;
      if (cfg_index == lco_pkg::REG_Y_MAX) win_r.y_max <= cfg_data;
    end
  end

  // outcodes of the current endpoints
  assign c0     = lco_pkg::outcode(x0_r, y0_r, win_r);
  assign c1     = lco_pkg::outcode(x1_r, y1_r, win_r);
  assign all_in = ((c0 | c1) == 4'b0000);
  assign reject = ((c0 & c1) != 4'b0000) || (round_r == lco_pkg::MAX_ROUNDS);
  assign csel   = (c0 != 4'b0000) ? c0 : c1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lco_pkg::S_IDLE:  if (start) state_nxt = lco_pkg::S_CHECK;
      lco_pkg::S_CHECK: state_nxt = (all_in || reject) ? lco_pkg::S_DONE : lco_pkg::S_WAIT;
      lco_pkg::S_WAIT:  if (rsp.done) state_nxt = lco_pkg::S_CHECK;
      lco_pkg::S_DONE:  state_nxt = lco_pkg::S_IDLE;
      default:          state_nxt = lco_pkg::S_IDLE;
    endcase
  end

  // outputs and move setup
  always_comb begin
    busy         = (state_r != lco_pkg::S_IDLE);
    out_valid    = (state_r == lco_pkg::S_DONE);
    verdict_nxt  = verdict_r;
    mv_first_nxt = mv_first_r;
    horiz_nxt    = horiz_r;
    edge_nxt     = edge_r;
    req.go       = 1'b0;
    req.a        = lco_pkg::diff(x1_r, x0_r);
    req.b        = lco_pkg::diff(win_r.y_max, y0_r);
    req.d        = lco_pkg::diff(y1_r, y0_r);
    req.base     = x0_r;

    // pick the crossed edge: top, bottom, right, left
    priority if ((csel & lco_pkg::CODE_TOP) != 4'b0000) begin
      horiz_nxt = 1'b1;
      edge_nxt  = win_r.y_max;
    end else if ((csel & lco_pkg::CODE_BOTTOM) != 4'b0000) begin
      horiz_nxt = 1'b1;
      edge_nxt  = win_r.y_min;
      req.b     = lco_pkg::diff(win_r.y_min, y0_r);
    end else if ((csel & lco_pkg::CODE_RIGHT) != 4'b0000) begin
      horiz_nxt = 1'b0;
      edge_nxt  = win_r.x_max;
    end else begin
      horiz_nxt = 1'b0;
      edge_nxt  = win_r.x_min;
    end

    // right/left edges solve for y along x
    if (!horiz_nxt) begin
      req.a    = lco_pkg::diff(y1_r, y0_r);
      req.b    = lco_pkg::diff(edge_nxt, x0_r);
      req.d    = lco_pkg::diff(x1_r, x0_r);
      req.base = y0_r;
    end

    if (state_r == lco_pkg::S_CHECK) begin
      if (all_in) begin
        verdict_nxt = (round_r == '0) ? lco_pkg::VERDICT_INSIDE : lco_pkg::VERDICT_CLIPPED;
      end else if (reject) begin
        verdict_nxt = lco_pkg::VERDICT_REJECT;
      end else begin
        req.go       = 1'b1;
        mv_first_nxt = (c0 != 4'b0000);
      end
    end else begin
      horiz_nxt = horiz_r;
      edge_nxt  = edge_r;
    end

    out_data.verdict = verdict_r;
    if (verdict_r == lco_pkg::VERDICT_REJECT) begin
      out_data.clip_start_x = '0;
      out_data.clip_start_y = '0;
      out_data.clip_end_x   = '0;
      out_data.clip_end_y   = '0;
    end else begin
      out_data.clip_start_x = x0_r;
      out_data.clip_start_y = y0_r;
      out_data.clip_end_x   = x1_r;
      out_data.clip_end_y   = y1_r;
    end
  end

  // new endpoint from the unit result and the edge value
  assign nx = horiz_r ? rsp.result : edge_r;
  assign ny = horiz_r ? edge_r : rsp.result;

  lco_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lco_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    verdict_r  <= verdict_nxt;
    mv_first_r <= mv_first_nxt;
    horiz_r    <= horiz_nxt;
    edge_r     <= edge_nxt;
    if (state_r == lco_pkg::S_IDLE && start) begin
      x0_r    <= in_data.start_x;
      y0_r    <= in_data.start_y;
      x1_r    <= in_data.end_x;
      y1_r    <= in_data.end_y;
      round_r <= '0;
    end else if (state_r == lco_pkg::S_WAIT && rsp.done) begin
      round_r <= round_r + 1'b1;
      if (mv_first_r) begin
        x0_r <= nx;
        y0_r <= ny;
      end else begin
        x1_r <= nx;
        y1_r <= ny;
      end
    end
  end

  // a result only appears while a segment is in flight
  a_valid_busy : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while idle");

  // an accepted segment keeps the block busy in the next cycle
  a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted segment did not raise busy");

  // a rejected segment reports zero coordinates
  a_reject_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.verdict == lco_pkg::VERDICT_REJECT) |->
      (out_data.clip_start_x == '0 && out_data.clip_start_y == '0 &&
       out_data.clip_end_x == '0 && out_data.clip_end_y == '0))
    else $error("rejected segment with nonzero coordinates");

  // the unit only finishes while the sequencer waits for it
  a_done_wait : assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> (state_r == lco_pkg::S_WAIT))
    else $error("mul/div finished outside of a move");

endmodule

// ===== sim/tb_line_clipper_outcode.sv =====
`timescale 1ns / 1ps
// self-checking testbench for line_clipper_outcode: directed and random segments
// checked against a local outcode clipping predictor; depends on lco_pkg and the dut
module tb_line_clipper_outcode;
  import lco_pkg::*;

  localparam int    CYCLE_LIMIT  = 1_000_000;
  localparam int    DRAIN_CYCLES = 4 * (PROD_W + 4) + 10;   // longest clip plus margin
  localparam int    ERROR_PRINTS = 50;
  localparam int    MOVE_ROUNDS  = int'(MAX_ROUNDS);
  localparam longint QUOT_LIMIT  = longint'(1) << QUOT_CAP_LG;

  // indexes past the window registers, the block must drop these
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_Y_MAX + CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED  = '1;

  logic    clk       = 1'b0;
  logic    rst_n     = 1'b0;
  logic    start     = 1'b0;
  logic    busy;
  in_t     in_data   = '0;
  logic    out_valid;
  out_t    out_data;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  coord_t  cfg_data  = '0;

  // local copy of the clip window, updated when a config word is taken
  win_t    window;
  // expected results still owed by the block, oldest first
  out_t    pending_clips[$];

  int      errors        = 0;
  int      cycles        = 0;
  int      results_seen  = 0;
  int      n_inside      = 0;
  int      n_clipped     = 0;
  int      n_rejected    = 0;
  int      n_windows     = 0;
  int      n_reg_writes  = 0;
  int      n_dropped     = 0;
  bit      no_idle       = 1'b0;

  line_clipper_outcode dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycles,
               pending_clips.size());
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic coord_t clamp_coord(longint v);
    if (v > longint'(COORD_MAX)) return COORD_MAX;
    if (v < longint'(COORD_MIN)) return COORD_MIN;
    return coord_t'(v);
  endfunction

  // outside bits of a point against the current window, strict compares
  function automatic logic [3:0] region_of(longint x, longint y);
    logic [3:0] c;
    c = '0;
    if (y > longint'($signed(window.y_max))) c = c | CODE_TOP;
    if (y < longint'($signed(window.y_min))) c = c | CODE_BOTTOM;
    if (x > longint'($signed(window.x_max))) c = c | CODE_RIGHT;
    if (x < longint'($signed(window.x_min))) c = c | CODE_LEFT;
    return c;
  endfunction

  // a*b/d truncated toward zero, capped at +-2^40, zero for d == 0; the product of two 17-bit differences fits easily
  function automatic longint scaled_quotient(longint a, longint b, longint d);
    longint q;
    if (d == 0) return 0;
    q = (a * b) / d;
    if (q > QUOT_LIMIT) q = QUOT_LIMIT;
    else if (q < -QUOT_LIMIT) q = -QUOT_LIMIT;
    return q;
  endfunction

  function automatic out_t clip_segment(in_t seg);
    longint     x0, y0, x1, y1, nx, ny;
    longint     wx0, wy0, wx1, wy1;
    logic [3:0] c0, c1, c;
    verdict_t   v;
    bit         settled;
    int         rnd;
    out_t       r;
    x0  = $signed(seg.start_x);
    y0  = $signed(seg.start_y);
    x1  = $signed(seg.end_x);
    y1  = $signed(seg.end_y);
    wx0 = $signed(window.x_min);
    wy0 = $signed(window.y_min);
    wx1 = $signed(window.x_max);
    wy1 = $signed(window.y_max);
    v = VERDICT_REJECT;
    settled = 1'b0;
    for (rnd = 0; rnd <= MOVE_ROUNDS && !settled; rnd++) begin
      c0 = region_of(x0, y0);
      c1 = region_of(x1, y1);
      if ((c0 | c1) == 4'b0) begin
        v = (rnd == 0) ? VERDICT_INSIDE : VERDICT_CLIPPED;
        settled = 1'b1;
      end else if ((c0 & c1) != 4'b0 || rnd == MOVE_ROUNDS) begin
        // trivially outside, or still not inside after the last move
        v = VERDICT_REJECT;
        settled = 1'b1;
      end else begin
        // move the first outside endpoint; edge priority top, bottom, right, left
        c = (c0 != 4'b0) ? c0 : c1;
        if ((c & CODE_TOP) != 4'b0) begin
          nx = clamp_coord(x0 + scaled_quotient(x1 - x0, wy1 - y0, y1 - y0));
          ny = wy1;
        end else if ((c & CODE_BOTTOM) != 4'b0) begin
          nx = clamp_coord(x0 + scaled_quotient(x1 - x0, wy0 - y0, y1 - y0));
          ny = wy0;
        end else if ((c & CODE_RIGHT) != 4'b0) begin
          ny = clamp_coord(y0 + scaled_quotient(y1 - y0, wx1 - x0, x1 - x0));
          nx = wx1;
        end else begin
          ny = clamp_coord(y0 + scaled_quotient(y1 - y0, wx0 - x0, x1 - x0));
          nx = wx0;
        end
        if (c0 != 4'b0) begin
          x0 = nx;
          y0 = ny;
        end else begin
          x1 = nx;
          y1 = ny;
        end
      end
    end
    r = '0;
    r.verdict = v;
    if (v != VERDICT_REJECT) begin
      r.clip_start_x = coord_t'(x0);
      r.clip_start_y = coord_t'(y0);
      r.clip_end_x   = coord_t'(x1);
      r.clip_end_y   = coord_t'(y1);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic report_error(input string msg);
    errors++;
    if (errors <= ERROR_PRINTS) $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [COORD_BITS-1:0] got,
                             input logic [COORD_BITS-1:0] want);
    if (got !== want)
      report_error($sformatf("result %0d %s: got %0d expected %0d", results_seen, name,
                             $signed(got), $signed(want)));
  endtask

  // results cannot be held off, so every strobe is taken at the edge that ends it
  always @(posedge clk) begin : take_result
    out_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_clips.size() == 0) begin
        report_error($sformatf("result word with nothing owed, verdict %0d", out_data.verdict));
      end else begin
        want = pending_clips.pop_front();
        check_field("verdict", COORD_BITS'(out_data.verdict), COORD_BITS'(want.verdict));
        check_field("clip_start_x", out_data.clip_start_x, want.clip_start_x);
        check_field("clip_start_y", out_data.clip_start_y, want.clip_start_y);
        check_field("clip_end_x", out_data.clip_end_x, want.clip_end_x);
        check_field("clip_end_y", out_data.clip_end_y, want.clip_end_y);
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // mostly back to back, some short gaps, a few long ones that outlast the block
  function automatic int next_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(8, 40);
    return $urandom_range(100, 200);
  endfunction

  // one segment word; start stays high across back-to-back words and while busy
  task automatic send_segment(input in_t seg);
    int gap;
    out_t want;
    gap = next_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= seg;
    start   <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    // taken at this edge
    want = clip_segment(seg);
    pending_clips.push_back(want);
    case (want.verdict)
      VERDICT_INSIDE:  n_inside++;
      VERDICT_CLIPPED: n_clipped++;
      default:         n_rejected++;
    endcase
  endtask

  // block idle: nothing owed and busy low
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_clips.size() != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  // one config word; valid is left high so words can go back to back
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input coord_t val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    n_reg_writes++;
    case (idx)
      REG_X_MIN: window.x_min = val;
      REG_Y_MIN: window.y_min = val;
      REG_X_MAX: window.x_max = val;
      REG_Y_MAX: window.y_max = val;
      default:   n_dropped++;
    endcase
  endtask

  task automatic set_window(input int x_lo, input int y_lo, input int x_hi, input int y_hi);
    wait_idle();
    write_reg(REG_X_MIN, clamp_coord(x_lo));
    write_reg(REG_Y_MIN, clamp_coord(y_lo));
    write_reg(REG_X_MAX, clamp_coord(x_hi));
    write_reg(REG_Y_MAX, clamp_coord(y_hi));
    cfg_valid <= 1'b0;
    n_windows++;
  endtask

  function automatic in_t make_seg(int sx, int sy, int ex, int ey);
    in_t s;
    s.start_x = coord_t'(sx);
    s.start_y = coord_t'(sy);
    s.end_x   = coord_t'(ex);
    s.end_y   = coord_t'(ey);
    return s;
  endfunction

  // coordinate on one axis: near the window, full range, on an edge, or an extreme
  function automatic coord_t pick_coord(bit is_y);
    int lo, hi, a, b, r;
    lo = is_y ? $signed(window.y_min) : $signed(window.x_min);
    hi = is_y ? $signed(window.y_max) : $signed(window.x_max);
    r = $urandom_range(0, 99);
    if (r < 45) begin
      a = ((lo < hi) ? lo : hi) - 200;
      b = ((lo < hi) ? hi : lo) + 200;
      a = clamp_coord(a);
      b = clamp_coord(b);
      return coord_t'(a + int'($urandom_range(0, b - a)));
    end
    if (r < 70) return coord_t'($urandom);
    if (r < 85)
      return clamp_coord(($urandom_range(0, 1) ? lo : hi) + int'($urandom_range(0, 2)) - 1);
    case ($urandom_range(0, 3))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2:       return coord_t'(0);
      default: return coord_t'(-1);
    endcase
  endfunction

  function automatic in_t random_segment();
    in_t s;
    s.start_x = pick_coord(1'b0);
    s.start_y = pick_coord(1'b1);
    s.end_x   = pick_coord(1'b0);
    s.end_y   = pick_coord(1'b1);
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // window as it comes out of reset: 0..max on both axes
  task automatic test_reset_window();
    send_segment(make_seg(10, 10, 1000, 2000));
    send_segment(make_seg(-10, -10, 100, 100));
    send_segment(make_seg(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
    send_segment(make_seg(-5, -5, -1, -1));
  endtask

  // written window: inside, edges, trivial rejects, one clip per edge and corner miss
  task automatic test_written_window();
    set_window(-100, -50, 100, 50);
    send_segment(make_seg(0, 0, 10, -10));
    send_segment(make_seg(-100, -50, 100, 50));        // endpoints on the edges count inside
    send_segment(make_seg(-10, 60, 10, 70));
    send_segment(make_seg(-10, -60, 10, -70));
    send_segment(make_seg(150, 0, 200, 10));
    send_segment(make_seg(-150, 0, -200, 10));
    send_segment(make_seg(0, 0, 30, 90));              // crosses top
    send_segment(make_seg(0, 0, -30, -90));            // crosses bottom
    send_segment(make_seg(0, 0, 300, 17));             // crosses right
    send_segment(make_seg(-300, -17, 0, 0));           // crosses left, start moves
    send_segment(make_seg(-300, -20, 300, 25));        // both ends move
    send_segment(make_seg(-150, 40, -60, 120));        // misses the corner after a move
    send_segment(make_seg(0, -200, 0, 200));
    send_segment(make_seg(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
    send_segment(make_seg(5, 5, 5, 5));
    send_segment(make_seg(500, 500, 500, 500));
  endtask

  // min above max: same outcode rules, no special handling
  task automatic test_inverted_window();
    set_window(100, 50, -100, -50);
    send_segment(make_seg(-200, 0, 200, 0));
    send_segment(make_seg(200, -200, -200, 200));
    send_segment(make_seg(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN));
  endtask

  // words to indexes past the last register must leave the window alone
  task automatic test_unused_index();
    wait_idle();
    write_reg(REG_FIRST_UNUSED, coord_t'($urandom));
    write_reg(REG_LAST_UNUSED, coord_t'($urandom));
    write_reg(CFG_IDX_W'($urandom_range(int'(REG_FIRST_UNUSED), int'(REG_LAST_UNUSED))),
              coord_t'($urandom));
    cfg_valid <= 1'b0;
    send_segment(make_seg(-200, 0, 200, 0));
    send_segment(make_seg(0, -20, 60, 20));
  endtask

  // several window settings, each with a batch of random segments
  task automatic test_random_segments();
    int ph, a, b, c, d, w, h;
    for (ph = 0; ph < 8; ph++) begin
      a = $signed(coord_t'($urandom));
      b = $signed(coord_t'($urandom));
      c = $signed(coord_t'($urandom));
      d = $signed(coord_t'($urandom));
      case (ph)
        0, 7: set_window((a < b) ? a : b, (c < d) ? c : d, (a < b) ? b : a, (c < d) ? d : c);
        1:    set_window(int'(COORD_MIN), int'(COORD_MIN), int'(COORD_MAX), int'(COORD_MAX));
        2:    set_window((a < b) ? b : a, (c < d) ? d : c, (a < b) ? a : b, (c < d) ? c : d);
        3: begin
          // small window, where most segments need real clipping
          w = $urandom_range(0, 300);
          h = $urandom_range(0, 300);
          set_window(a - w, c - h, a + w, c + h);
        end
        4:    set_window(a, c, a, c);                  // single point window
        5: begin
          // pinned in a corner of the coordinate range
          w = $urandom_range(0, 200);
          h = $urandom_range(0, 200);
          set_window(int'(COORD_MIN), int'(COORD_MAX) - h, int'(COORD_MIN) + w, int'(COORD_MAX));
        end
        default: set_window(0, 0, int'(COORD_MAX), int'(COORD_MAX));
      endcase
      no_idle = (ph == 2 || ph == 5);
      repeat (116) send_segment(random_segment());
    end
    no_idle = 1'b0;
  endtask

  initial begin
    window.x_min = '0;
    window.y_min = '0;
    window.x_max = COORD_MAX;
    window.y_max = COORD_MAX;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_window();
    test_written_window();
    test_inverted_window();
    test_unused_index();
    test_random_segments();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d segments (%0d inside, %0d clipped, %0d rejected) over %0d windows",
             n_inside + n_clipped + n_rejected, n_inside, n_clipped, n_rejected, n_windows);
    $display("%0d config words, %0d to unused indexes; %0d results checked, %0d errors",
             n_reg_writes, n_dropped, results_seen, errors);
    if (errors == 0 && pending_clips.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/lco_pkg.sv
sv/lco_muldiv.sv
sv/line_clipper_outcode.sv
sim/tb_line_clipper_outcode.sv
